[rtl/core/assert_macros.svh]
// Assertion macros shared by the RTL of the mecanum mixer.
// Depends on nothing; include by bare file name after the module header.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent assertion, clocked on the rising edge, off while reset is held.
`define ASSERT_CLKD(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Implication form: whenever the trigger holds, the consequence holds too.
`define ASSERT_IMPL(lbl, clk, rst_n, trig, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (trig) |-> (cons)) \
		else $error(msg);

`endif

[rtl/core/mmnp_pkg.sv]
// Shared types and constants of the mecanum mixer: field widths,
// parameter defaults and the direction codes. Depends on nothing.
`default_nettype none

package mmnp_pkg;

	localparam int IN_W        = 16; // velocity field width
	localparam int MAG_W       = 17; // width of |vy +/- vx|
	localparam int DUTY_W      = 8;  // duty field width
	localparam int DIR_W       = 2;  // direction field width

	localparam int FRAC_BITS_DEF = 14;
	localparam int DUTY_BITS_DEF = 8;

	// Restoring-division steps done per divider register rank
	localparam int DIV_STEPS   = 4;

	typedef enum logic [DIR_W-1:0] {
		DIR_STOP = 2'd0,
		DIR_FWD  = 2'd1,
		DIR_REV  = 2'd2
	} dir_t;

endpackage

`default_nettype wire

[rtl/core/mecanum_mix_normalize_pwm_top.sv]
// Top level of the mecanum mixer: wheel mixing, normalisation divider,
// direction and duty encoding. Depends on mmnp_pkg and assert_macros.svh.
`default_nettype none

// Mecanum wheel mixer. One velocity command (vel_x lateral, vel_y forward,
// signed fixed point with FRAC_BITS fraction bits) is taken per transaction
// and gives exactly one result transaction carrying a direction code and a
// duty value for each of the four wheels. Front-left and rear-right run on
// vel_y + vel_x, front-right and rear-left on vel_y - vel_x. When the larger
// magnitude exceeds 1.0 both speeds are scaled by 1.0 / max, truncating
// toward zero; duty is floor(|speed| * (2^DUTY_BITS - 1)), saturated, and
// the low eight bits are presented. A new command is accepted every cycle
// while in_stall is low. A command passes 4 + ceil((FRAC_BITS + 1) / 4)
// register ranks; the normalisation divider, which retires four quotient
// bits per register rank, supplies ceil((FRAC_BITS + 1) / 4) of them.
// Stalls hold the pipeline in place rank by rank, and empty ranks keep
// filling, so bubbles collapse and no transaction is lost or repeated.
module mecanum_mix_normalize_pwm_top
	import mmnp_pkg::*;
#(
	parameter int FRAC_BITS = FRAC_BITS_DEF,
	parameter int DUTY_BITS = DUTY_BITS_DEF
) (
	input  wire logic              clk,
	input  wire logic              arst_n,

	input  wire logic              in_valid,
	output logic                   in_stall,
	input  wire logic [IN_W-1:0]   vel_x,
	input  wire logic [IN_W-1:0]   vel_y,

	output logic                   out_valid,
	input  wire logic              out_stall,
	output logic [DIR_W-1:0]       fl_dir,
	output logic [DUTY_W-1:0]      fl_duty,
	output logic [DIR_W-1:0]       fr_dir,
	output logic [DUTY_W-1:0]      fr_duty,
	output logic [DIR_W-1:0]       rl_dir,
	output logic [DUTY_W-1:0]      rl_duty,
	output logic [DIR_W-1:0]       rr_dir,
	output logic [DUTY_W-1:0]      rr_duty
);

`include "assert_macros.svh"

	// Quotient width: the scaled speed never exceeds 1.0
	localparam int QW = FRAC_BITS + 1;
	// Divider register ranks
	localparam int DS = (QW + DIV_STEPS - 1) / DIV_STEPS;
	// Compare width for max > 1.0
	localparam int CW = MAG_W + FRAC_BITS + 1;
	localparam logic [CW-1:0] ONE_C = CW'(1) << FRAC_BITS;
	localparam logic [QW-1:0] ONE_Q = QW'(1) << FRAC_BITS;
	// Duty product width
	localparam int PW = MAG_W + DUTY_BITS;
	localparam logic [DUTY_BITS-1:0] DUTY_MAX = {DUTY_BITS{1'b1}};

	// Record carried through the normalisation divider. Suffix a is the
	// vel_y + vel_x speed (fl, rr), suffix b the vel_y - vel_x speed (fr, rl).
	typedef struct packed {
		logic [MAG_W-1:0] m;
		logic             norm;
		logic             neg_a;
		logic             neg_b;
		logic [MAG_W-1:0] mag_a;
		logic [MAG_W-1:0] mag_b;
		logic [MAG_W-1:0] r_a;
		logic [MAG_W-1:0] r_b;
		logic [QW-1:0]    q_a;
		logic [QW-1:0]    q_b;
	} div_rec_t;

	// One restoring-division step: returns {quotient bit, remainder}
	function automatic logic [MAG_W:0] div_step(input logic [MAG_W:0] t,
			input logic [MAG_W-1:0] d);
		logic [MAG_W:0] dd;
		logic [MAG_W:0] diff;
		dd   = {1'b0, d};
		diff = t - dd;
		if (t >= dd)
			return {1'b1, diff[MAG_W-1:0]};
		else
			return {1'b0, t[MAG_W-1:0]};
	endfunction

	// ---------------------------------------------------------------
	// Flow control: a rank advances when it is empty or the rank after
	// it advances; the output register frees when the sink takes it.
	// ---------------------------------------------------------------
	logic en_s1, en_s2, en_s4, en_s5;
	logic div_en [DS];

	logic vld_s1, vld_s2, vld_s4, vld_s5;
	logic div_vld_s3 [DS];

	assign en_s5    = !vld_s5 || !out_stall;
	assign en_s4    = !vld_s4 || en_s5;
	assign en_s2    = !vld_s2 || div_en[0];
	assign en_s1    = !vld_s1 || en_s2;
	assign in_stall = !en_s1;

	// ---------------------------------------------------------------
	// Stage 1: mix. Sign-extend and form the two distinct wheel speeds.
	// ---------------------------------------------------------------
	logic [MAG_W-1:0] spd_a_s1, spd_b_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (en_s1) begin
			vld_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en_s1) begin
			spd_a_s1 <= {vel_y[IN_W-1], vel_y} + {vel_x[IN_W-1], vel_x};
			spd_b_s1 <= {vel_y[IN_W-1], vel_y} - {vel_x[IN_W-1], vel_x};
		end
	end

	// ---------------------------------------------------------------
	// Stage 2: magnitudes, the larger of the two, and whether to scale.
	// ---------------------------------------------------------------
	div_rec_t         rec_s2;
	div_rec_t         rec_nxt_s2;
	logic [MAG_W-1:0] mag_a_c, mag_b_c, m_c;

	always_comb begin
		mag_a_c = spd_a_s1[MAG_W-1] ? (~spd_a_s1 + MAG_W'(1)) : spd_a_s1;
		mag_b_c = spd_b_s1[MAG_W-1] ? (~spd_b_s1 + MAG_W'(1)) : spd_b_s1;
		m_c     = (mag_a_c > mag_b_c) ? mag_a_c : mag_b_c;

		rec_nxt_s2       = '0;
		rec_nxt_s2.m     = m_c;
		rec_nxt_s2.norm  = CW'(m_c) > ONE_C;
		rec_nxt_s2.neg_a = spd_a_s1[MAG_W-1];
		rec_nxt_s2.neg_b = spd_b_s1[MAG_W-1];
		rec_nxt_s2.mag_a = mag_a_c;
		rec_nxt_s2.mag_b = mag_b_c;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2 <= 1'b0;
		end else if (en_s2) begin
			vld_s2 <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en_s2) begin
			rec_s2 <= rec_nxt_s2;
		end
	end

	// ---------------------------------------------------------------
	// Stage 3: normalisation divider, DS ranks deep. Computes
	// |speed| * 2^FRAC_BITS / max one quotient bit a step. The first step
	// compares |speed| itself (speed <= max, so that bit weighs 1.0); each
	// later step doubles the remainder. Index 0 of the arrays is rank 0.
	// ---------------------------------------------------------------
	div_rec_t div_rec_s3 [DS];

	for (genvar k = 0; k < DS; k++) begin : g_div
		div_rec_t prev;
		div_rec_t nxt;
		logic     prev_vld;

		if (k == 0) begin : g_first
			assign prev     = rec_s2;
			assign prev_vld = vld_s2;
		end else begin : g_next
			assign prev     = div_rec_s3[k-1];
			assign prev_vld = div_vld_s3[k-1];
		end

		if (k == DS - 1) begin : g_en_last
			assign div_en[k] = !div_vld_s3[k] || en_s4;
		end else begin : g_en_mid
			assign div_en[k] = !div_vld_s3[k] || div_en[k+1];
		end

		always_comb begin
			logic [MAG_W:0] t_a;
			logic [MAG_W:0] t_b;
			logic [MAG_W:0] res_a;
			logic [MAG_W:0] res_b;
			nxt   = prev;
			t_a   = '0;
			t_b   = '0;
			res_a = '0;
			res_b = '0;
			for (int j = 0; j < DIV_STEPS; j++) begin
				if (k * DIV_STEPS + j < QW) begin
					if (k * DIV_STEPS + j == 0) begin
						t_a = {1'b0, nxt.mag_a};
						t_b = {1'b0, nxt.mag_b};
					end else begin
						t_a = {nxt.r_a, 1'b0};
						t_b = {nxt.r_b, 1'b0};
					end
					res_a   = div_step(t_a, nxt.m);
					res_b   = div_step(t_b, nxt.m);
					nxt.r_a = res_a[MAG_W-1:0];
					nxt.r_b = res_b[MAG_W-1:0];
					nxt.q_a = {nxt.q_a[QW-2:0], res_a[MAG_W]};
					nxt.q_b = {nxt.q_b[QW-2:0], res_b[MAG_W]};
				end
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				div_vld_s3[k] <= 1'b0;
			end else if (div_en[k]) begin
				div_vld_s3[k] <= prev_vld;
			end
		end

		always_ff @(posedge clk) begin
			if (div_en[k]) begin
				div_rec_s3[k] <= nxt;
			end
		end
	end

	// ---------------------------------------------------------------
	// Stage 4: pick scaled or raw magnitude, encode direction, and
	// multiply by the full-scale duty.
	// ---------------------------------------------------------------
	div_rec_t         last_rec;
	logic [MAG_W-1:0] sel_a_c, sel_b_c;
	dir_t             dir_a_c, dir_b_c;
	dir_t             dir_a_s4, dir_b_s4;
	logic [PW-1:0]    prod_a_s4, prod_b_s4;

	assign last_rec = div_rec_s3[DS-1];

	always_comb begin
		logic [QW+MAG_W-1:0] qa_ext;
		logic [QW+MAG_W-1:0] qb_ext;
		qa_ext  = {{MAG_W{1'b0}}, last_rec.q_a};
		qb_ext  = {{MAG_W{1'b0}}, last_rec.q_b};
		sel_a_c = last_rec.norm ? qa_ext[MAG_W-1:0] : last_rec.mag_a;
		sel_b_c = last_rec.norm ? qb_ext[MAG_W-1:0] : last_rec.mag_b;

		// A speed that truncates to zero is a stop, whatever its sign
		if (sel_a_c == '0)
			dir_a_c = DIR_STOP;
		else if (last_rec.neg_a)
			dir_a_c = DIR_REV;
		else
			dir_a_c = DIR_FWD;

		if (sel_b_c == '0)
			dir_b_c = DIR_STOP;
		else if (last_rec.neg_b)
			dir_b_c = DIR_REV;
		else
			dir_b_c = DIR_FWD;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s4 <= 1'b0;
		end else if (en_s4) begin
			vld_s4 <= div_vld_s3[DS-1];
		end
	end

	always_ff @(posedge clk) begin
		if (en_s4) begin
			dir_a_s4  <= dir_a_c;
			dir_b_s4  <= dir_b_c;
			prod_a_s4 <= PW'(sel_a_c) * PW'(DUTY_MAX);
			prod_b_s4 <= PW'(sel_b_c) * PW'(DUTY_MAX);
		end
	end

	// ---------------------------------------------------------------
	// Stage 5: drop the fraction, saturate, and hold the result for the
	// sink. A zero speed has a zero product, so its duty is zero.
	// ---------------------------------------------------------------
	logic [PW-1:0]        shf_a_c, shf_b_c;
	logic [DUTY_BITS-1:0] sat_a_c, sat_b_c;
	logic [DUTY_W-1:0]    duty_a_c, duty_b_c;
	dir_t                 dir_a_s5, dir_b_s5;
	logic [DUTY_W-1:0]    duty_a_s5, duty_b_s5;

	always_comb begin
		logic [DUTY_BITS+DUTY_W-1:0] ext_a;
		logic [DUTY_BITS+DUTY_W-1:0] ext_b;
		shf_a_c  = prod_a_s4 >> FRAC_BITS;
		shf_b_c  = prod_b_s4 >> FRAC_BITS;
		sat_a_c  = (shf_a_c > PW'(DUTY_MAX)) ? DUTY_MAX : shf_a_c[DUTY_BITS-1:0];
		sat_b_c  = (shf_b_c > PW'(DUTY_MAX)) ? DUTY_MAX : shf_b_c[DUTY_BITS-1:0];
		ext_a    = (DUTY_BITS+DUTY_W)'(sat_a_c);
		ext_b    = (DUTY_BITS+DUTY_W)'(sat_b_c);
		duty_a_c = ext_a[DUTY_W-1:0];
		duty_b_c = ext_b[DUTY_W-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s5 <= 1'b0;
		end else if (en_s5) begin
			vld_s5 <= vld_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (en_s5) begin
			dir_a_s5  <= dir_a_s4;
			dir_b_s5  <= dir_b_s4;
			duty_a_s5 <= duty_a_c;
			duty_b_s5 <= duty_b_c;
		end
	end

	assign out_valid = vld_s5;
	assign fl_dir    = dir_a_s5;
	assign fl_duty   = duty_a_s5;
	assign rr_dir    = dir_a_s5;
	assign rr_duty   = duty_a_s5;
	assign fr_dir    = dir_b_s5;
	assign fr_duty   = duty_b_s5;
	assign rl_dir    = dir_b_s5;
	assign rl_duty   = duty_b_s5;

	// ---------------------------------------------------------------
	// Checks
	// ---------------------------------------------------------------
	logic fl_stop_c, diag_ok_c, norm_vld_c, quot_ok_c;

	assign fl_stop_c  = out_valid && fl_dir == DIR_STOP;
	assign diag_ok_c  = fl_dir == rr_dir && fl_duty == rr_duty &&
		fr_dir == rl_dir && fr_duty == rl_duty;
	assign norm_vld_c = div_vld_s3[DS-1] && last_rec.norm;
	assign quot_ok_c  = last_rec.q_a <= ONE_Q && last_rec.q_b <= ONE_Q;

	`ASSERT_IMPL(a_stop_zero_duty, clk, arst_n, fl_stop_c, fl_duty == '0, "stop with duty")
	`ASSERT_IMPL(a_diag_match, clk, arst_n, out_valid, diag_ok_c, "diagonal wheels disagree")
	`ASSERT_IMPL(a_stall_full, clk, arst_n, in_stall, vld_s1 && vld_s2, "stall with free rank")
	`ASSERT_IMPL(a_quot_bound, clk, arst_n, norm_vld_c, quot_ok_c, "scaled speed above 1.0")

endmodule

`default_nettype wire

[tb/mmnp_wheel_checker.sv]
// Wheel result checker for the mecanum mixer: watches both channels, predicts
// the four wheel commands for each accepted velocity transaction and compares.
// Depends on mmnp_pkg for field widths and direction codes.
`default_nettype none

module mmnp_wheel_checker
	import mmnp_pkg::*;
#(
	parameter int FRAC_BITS = FRAC_BITS_DEF,
	parameter int DUTY_BITS = DUTY_BITS_DEF
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              in_valid,
	input  wire logic              in_stall,
	input  wire logic [IN_W-1:0]   vel_x,
	input  wire logic [IN_W-1:0]   vel_y,
	input  wire logic              out_valid,
	input  wire logic              out_stall,
	input  wire logic [DIR_W-1:0]  fl_dir,
	input  wire logic [DUTY_W-1:0] fl_duty,
	input  wire logic [DIR_W-1:0]  fr_dir,
	input  wire logic [DUTY_W-1:0] fr_duty,
	input  wire logic [DIR_W-1:0]  rl_dir,
	input  wire logic [DUTY_W-1:0] rl_duty,
	input  wire logic [DIR_W-1:0]  rr_dir,
	input  wire logic [DUTY_W-1:0] rr_duty,
	output int                     fail_count,
	output int                     outstanding
);

	// Wheel order throughout: 0 front left, 1 front right, 2 rear left, 3 rear right
	typedef struct packed {
		logic [3:0][DIR_W-1:0]  dir;
		logic [3:0][DUTY_W-1:0] duty;
	} wheel_cmd_t;

	wheel_cmd_t pending_wheels[$];
	int         err_cnt;

	function automatic wheel_cmd_t mix_command(logic [IN_W-1:0] x, logic [IN_W-1:0] y);
		longint     unit_speed;
		longint     duty_full;
		longint     vx;
		longint     vy;
		longint     spd[4];
		longint     peak;
		longint     mag;
		longint     duty;
		wheel_cmd_t res;
		unit_speed = longint'(1) << FRAC_BITS;
		duty_full  = (longint'(1) << DUTY_BITS) - 1;
		vx = longint'($signed(x));
		vy = longint'($signed(y));
		spd[0] = vy + vx;
		spd[1] = vy - vx;
		spd[2] = vy - vx;
		spd[3] = vy + vx;
		peak = 0;
		for (int w = 0; w < 4; w++) begin
			mag = (spd[w] < 0) ? -spd[w] : spd[w];
			if (mag > peak)
				peak = mag;
		end
		for (int w = 0; w < 4; w++) begin
			mag = (spd[w] < 0) ? -spd[w] : spd[w];
			// normalise only when the largest wheel is strictly above 1.0
			if (peak > unit_speed)
				mag = (mag * unit_speed) / peak;
			if (mag == 0) begin
				res.dir[w]  = DIR_STOP;
				res.duty[w] = '0;
			end else begin
				res.dir[w] = (spd[w] < 0) ? DIR_REV : DIR_FWD;
				duty = (mag * duty_full) >>> FRAC_BITS;
				if (duty > duty_full)
					duty = duty_full;
				res.duty[w] = duty[DUTY_W-1:0];
			end
		end
		return res;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		wheel_cmd_t got;
		wheel_cmd_t want;
		logic       bad;
		if (!arst_n) begin
			pending_wheels.delete();
			err_cnt = 0;
			fail_count <= 0;
			outstanding <= 0;
		end else begin
			if (in_valid && !in_stall)
				pending_wheels.push_back(mix_command(vel_x, vel_y));
			if (out_valid && !out_stall) begin
				got.dir  = {rr_dir, rl_dir, fr_dir, fl_dir};
				got.duty = {rr_duty, rl_duty, fr_duty, fl_duty};
				if (pending_wheels.size() == 0) begin
					if (err_cnt < 10)
						$display("unexpected wheel result: fl %0d/%0d fr %0d/%0d rl %0d/%0d rr %0d/%0d",
							fl_dir, fl_duty, fr_dir, fr_duty, rl_dir, rl_duty, rr_dir, rr_duty);
					err_cnt++;
				end else begin
					want = pending_wheels.pop_front();
					bad  = 1'b0;
					for (int w = 0; w < 4; w++)
						if (got.dir[w] !== want.dir[w] || got.duty[w] !== want.duty[w])
							bad = 1'b1;
					if (bad) begin
						if (err_cnt < 10) begin
							$display("wheel mismatch want: fl %0d/%0d fr %0d/%0d rl %0d/%0d rr %0d/%0d",
								want.dir[0], want.duty[0], want.dir[1], want.duty[1],
								want.dir[2], want.duty[2], want.dir[3], want.duty[3]);
							$display("               got:  fl %0d/%0d fr %0d/%0d rl %0d/%0d rr %0d/%0d",
								fl_dir, fl_duty, fr_dir, fr_duty, rl_dir, rl_duty, rr_dir, rr_duty);
						end
						err_cnt++;
					end
				end
			end
			fail_count <= err_cnt;
			outstanding <= pending_wheels.size();
		end
	end

endmodule

`default_nettype wire

[tb/tb_mecanum_mix_normalize_pwm_top.sv]
// Testbench top for the mecanum mixer: drives velocity commands with bursty
// timing and a stalling receiver, and gives the verdict.
// Depends on mmnp_pkg, mmnp_wheel_checker and the mixer RTL.
`default_nettype none

module tb_mecanum_mix_normalize_pwm_top;
	import mmnp_pkg::*;

	localparam int RANDOM_CMDS  = 1200;
	localparam int HOLD_AT_CMD  = 400;  // start of the gap-free run during the long hold
	localparam int HOLD_CYCLES  = 300;
	localparam int DRAIN_CYCLES = 16;   // idle wait after the checker queue empties

	logic            clk;
	logic            arst_n;
	logic            in_valid;
	logic            in_stall;
	logic [IN_W-1:0] vel_x;
	logic [IN_W-1:0] vel_y;
	logic            out_valid;
	logic            out_stall;
	logic [DIR_W-1:0]  fl_dir, fr_dir, rl_dir, rr_dir;
	logic [DUTY_W-1:0] fl_duty, fr_duty, rl_duty, rr_duty;

	int fail_count;
	int outstanding;

	// Handshake between sender and receiver for the long hold-off
	bit hold_off_req;
	bit hold_off_done;

	mecanum_mix_normalize_pwm_top dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.vel_x     (vel_x),
		.vel_y     (vel_y),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.fl_dir    (fl_dir),
		.fl_duty   (fl_duty),
		.fr_dir    (fr_dir),
		.fr_duty   (fr_duty),
		.rl_dir    (rl_dir),
		.rl_duty   (rl_duty),
		.rr_dir    (rr_dir),
		.rr_duty   (rr_duty)
	);

	mmnp_wheel_checker checker_i (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.vel_x       (vel_x),
		.vel_y       (vel_y),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.fl_dir      (fl_dir),
		.fl_duty     (fl_duty),
		.fr_dir      (fr_dir),
		.fr_duty     (fr_duty),
		.rl_dir      (rl_dir),
		.rl_duty     (rl_duty),
		.rr_dir      (rr_dir),
		.rr_duty     (rr_duty),
		.fail_count  (fail_count),
		.outstanding (outstanding)
	);

	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	// Hold one command on the input channel until the mixer takes it.
	// Valid is raised here and only lowered by the caller at a burst end.
	task automatic send_cmd(input int x, input int y);
		in_valid <= 1'b1;
		vel_x    <= x[IN_W-1:0];
		vel_y    <= y[IN_W-1:0];
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
	endtask

	// Pick a random command, weighted towards the interesting corners of the
	// normaliser: the unit boundary, tiny speeds, cancelling wheels and extremes.
	task automatic pick_cmd(output int x, output int y);
		int picks[7];
		int sx;
		picks = '{-32768, -16384, -1, 0, 1, 16384, 32767};
		case ($urandom_range(0, 9))
			0, 1, 2: begin
				x = $signed(16'($urandom()));
				y = $signed(16'($urandom()));
			end
			3, 4: begin
				// within +/-1.0 per axis, about half below the normalisation threshold
				x = int'($urandom_range(0, 32768)) - 16384;
				y = int'($urandom_range(0, 32768)) - 16384;
			end
			5: begin
				// larger wheel lands just either side of exactly 1.0
				y  = int'($urandom_range(0, 16384));
				x  = 16384 - y + int'($urandom_range(0, 4)) - 2;
				sx = $urandom_range(0, 1) ? -1 : 1;
				x  = x * sx;
				y  = $urandom_range(0, 1) ? -y : y;
			end
			6: begin
				x = int'($urandom_range(0, 200)) - 100;
				y = int'($urandom_range(0, 200)) - 100;
			end
			7: begin
				// one axis idle
				x = $signed(16'($urandom()));
				y = 0;
				if ($urandom_range(0, 1)) begin
					y = x;
					x = 0;
				end
			end
			8: begin
				// x within one of +/-y: one wheel pair stops or nearly so, small after scaling
				y = $signed(16'($urandom()));
				if (y == -32768)
					y = -32767;
				x = $urandom_range(0, 1) ? y : -y;
				x = x + int'($urandom_range(0, 2)) - 1;
				if (x > 32767)
					x = 32767;
				if (x < -32768)
					x = -32768;
			end
			default: begin
				x = picks[$urandom_range(0, 6)];
				y = picks[$urandom_range(0, 6)];
			end
		endcase
	endtask

	// Receiver: switch between random stall patterns, and honour one
	// long hold-off when the sender asks for it.
	initial begin
		int mode;
		int left;
		out_stall = 1'b0;
		mode = 0;
		left = 0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (hold_off_req && !hold_off_done) begin
				out_stall <= 1'b1;
				repeat (HOLD_CYCLES)
					@(posedge clk);
				hold_off_done = 1'b1;
			end
			if (left == 0) begin
				mode = $urandom_range(0, 3);
				left = $urandom_range(20, 80);
			end
			left--;
			case (mode)
				0: out_stall <= 1'b0;
				1: out_stall <= ($urandom_range(0, 3) == 0);
				2: out_stall <= ($urandom_range(0, 3) != 0);
				default: out_stall <= ~out_stall;
			endcase
		end
	end

	initial begin
		#2000000;
		$display("CHECKS FAILED");
		$finish;
	end

	// Sender and verdict
	initial begin
		int dir_x[$];
		int dir_y[$];
		int x;
		int y;
		int burst_left;
		arst_n   = 1'b0;
		in_valid = 1'b0;
		vel_x    = '0;
		vel_y    = '0;
		hold_off_req  = 1'b0;
		hold_off_done = 1'b0;
		repeat (7)
			@(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed corners: zero, both extremes, exactly unit magnitude, just
		// over unit, wheels that cancel, speeds that truncate to a stop after
		// scaling, and duties that round down to zero while still moving.
		dir_x = '{0, 32767, -32768, 32767, -32768, 16384, 0, 8192, 8193, 32766,
			-1, 1, 0, -16384, 16383, 16384, -32768, 0, 32767, 12345, -12345, 16383};
		dir_y = '{0, 32767, -32768, -32768, 32767, 0, 16384, 8192, 8192, 32767,
			0, 0, -1, 0, 0, 1, 0, -32768, 0, -6789, 6789, -16383};
		foreach (dir_x[i])
			send_cmd(dir_x[i], dir_y[i]);
		in_valid <= 1'b0;
		@(posedge clk);

		burst_left = 0;
		for (int n = 0; n < RANDOM_CMDS; n++) begin
			if (n == HOLD_AT_CMD) begin
				hold_off_req = 1'b1;
				burst_left = 120;
			end
			if (burst_left == 0) begin
				// end of burst: drop valid, idle, then open a fresh burst
				in_valid <= 1'b0;
				vel_x    <= 16'($urandom());
				vel_y    <= 16'($urandom());
				repeat ($urandom_range(1, 8))
					@(posedge clk);
				burst_left = $urandom_range(0, 3) == 0 ? $urandom_range(30, 80)
					: $urandom_range(1, 12);
			end
			pick_cmd(x, y);
			send_cmd(x, y);
			burst_left--;
		end
		in_valid <= 1'b0;

		// Let the last push reach the checker, drain, then allow for latency
		@(posedge clk);
		while (outstanding != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES)
			@(posedge clk);

		if (fail_count == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

endmodule

`default_nettype wire
